FILE: rtl/core/cc20_pkg.sv
// Shared types, constants and the ChaCha20 quarter-round function.
package cc20_pkg;

   // Configuration register indexes
   localparam int CSR_AW = 3;
   localparam logic [CSR_AW-1:0] CSR_KEY_WORD0     = 3'd0;
   localparam logic [CSR_AW-1:0] CSR_KEY_WORD1     = 3'd1;
   localparam logic [CSR_AW-1:0] CSR_KEY_WORD2     = 3'd2;
   localparam logic [CSR_AW-1:0] CSR_KEY_WORD3     = 3'd3;
   localparam logic [CSR_AW-1:0] CSR_NONCE_LOW     = 3'd4;
   localparam logic [CSR_AW-1:0] CSR_NONCE_HIGH    = 3'd5;
   localparam logic [CSR_AW-1:0] CSR_START_COUNTER = 3'd6;

   localparam int TDATA_W = 72;
   localparam logic [3:0] FULL_COUNT = 4'd8;

   // Input queue
   localparam int Q_DEPTH = 4;
   localparam int Q_AW    = $clog2(Q_DEPTH);

   // Round sequencing: 20 rounds, alternating column and diagonal
   localparam logic [4:0] LAST_ROUND = 5'd19;

   localparam logic [31:0] SIGMA0 = 32'h61707865;
   localparam logic [31:0] SIGMA1 = 32'h3320646e;
   localparam logic [31:0] SIGMA2 = 32'h79622d32;
   localparam logic [31:0] SIGMA3 = 32'h6b206574;

   typedef struct packed {
      logic [63:0] key_word0;
      logic [63:0] key_word1;
      logic [63:0] key_word2;
      logic [63:0] key_word3;
      logic [63:0] nonce_low;
      logic [31:0] nonce_high;
      logic [31:0] start_counter;
   } cfg_type;

   // Classified input word as it sits in the queue
   typedef struct packed {
      logic [63:0] data;
      logic [3:0]  count;
      logic [7:0]  byte_en;
      logic        first;
   } item_type;

   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
      logic [31:0] d;
   } qr_type;

   typedef logic [15:0][31:0] state_type;
   typedef logic [7:0][63:0]  block_type;

   function automatic qr_type quarter_round(input logic [31:0] a_i, input logic [31:0] b_i,
                                            input logic [31:0] c_i, input logic [31:0] d_i);
      logic [31:0] a, b, c, d;
      qr_type r;
      a = a_i; b = b_i; c = c_i; d = d_i;
      a = a + b; d = d ^ a; d = {d[15:0], d[31:16]};
      c = c + d; b = b ^ c; b = {b[19:0], b[31:20]};
      a = a + b; d = d ^ a; d = {d[23:0], d[31:24]};
      c = c + d; b = b ^ c; b = {b[24:0], b[31:25]};
      r.a = a; r.b = b; r.c = c; r.d = d;
      return r;
   endfunction

   function automatic state_type init_state(input cfg_type cfg, input logic [31:0] ctr);
      state_type s;
      s[0]  = SIGMA0;
      s[1]  = SIGMA1;
      s[2]  = SIGMA2;
      s[3]  = SIGMA3;
      s[4]  = cfg.key_word0[31:0];
      s[5]  = cfg.key_word0[63:32];
      s[6]  = cfg.key_word1[31:0];
      s[7]  = cfg.key_word1[63:32];
      s[8]  = cfg.key_word2[31:0];
      s[9]  = cfg.key_word2[63:32];
      s[10] = cfg.key_word3[31:0];
      s[11] = cfg.key_word3[63:32];
      s[12] = ctr;
      s[13] = cfg.nonce_low[31:0];
      s[14] = cfg.nonce_low[63:32];
      s[15] = cfg.nonce_high;
      return s;
   endfunction

endpackage

FILE: rtl/core/cc20_front.sv
// Input side: accepts message words, clamps the byte count, builds byte enables, queues.
module cc20_front
   import cc20_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [TDATA_W-1:0]  req_tdata,
   input  logic                req_tuser,
   output logic                q_valid,
   output item_type            q_item,
   input  logic                q_pop
);

   item_type           mem_ff [Q_DEPTH];
   logic [Q_AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [Q_AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [Q_AW:0]      fill_ff, fill_in;
   item_type           new_item;
   logic               push;
   logic               pop;
   logic [3:0]         raw_count;

   assign req_tready = (fill_ff != (Q_AW+1)'(Q_DEPTH));
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (fill_ff != '0);
   assign pop        = q_pop && q_valid;
   assign q_item     = mem_ff[rd_ptr_ff];
   assign raw_count  = req_tdata[67:64];

   always_comb begin
      new_item.data  = req_tdata[63:0];
      new_item.first = req_tuser;
      new_item.count = (raw_count > FULL_COUNT) ? FULL_COUNT : raw_count;
      for (int j = 0; j < 8; j++) begin
         new_item.byte_en[j] = (4'(j) < new_item.count);
      end
   end

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + Q_AW'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + Q_AW'(1) : rd_ptr_ff;
      fill_in   = fill_ff + (Q_AW+1)'(push) - (Q_AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

FILE: rtl/core/cc20_core.sv
// Iterative ChaCha20 block function: four quarter rounds per cycle, then the feed-forward add.
module cc20_core
   import cc20_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  logic         start,
   input  logic [31:0]  ctr,
   output logic         done,
   output block_type    block
);

   typedef enum logic [1:0] {ST_IDLE, ST_ROUND, ST_FINAL} core_state_type;

   core_state_type  state_ff, state_in;
   state_type       x_ff, x_in;
   logic [31:0]     ctr_ff, ctr_in;
   logic [4:0]      round_ff, round_in;
   block_type       blk_ff, blk_in;
   logic            done_ff, done_in;
   state_type       x_round;
   state_type       s_orig;
   logic            diag;

   assign diag   = round_ff[0];
   assign s_orig = init_state(cfg, ctr_ff);
   assign done   = done_ff;
   assign block  = blk_ff;

   // One column or diagonal round; the four lanes are independent
   always_comb begin
      logic [1:0] lane, bl, cl, dl;
      qr_type q;
      x_round = x_ff;
      for (int i = 0; i < 4; i++) begin
         lane = 2'(i);
         bl   = lane + {1'b0, diag};
         cl   = lane + {diag, 1'b0};
         dl   = lane + {diag, diag};
         q = quarter_round(x_ff[{2'b00, lane}], x_ff[{2'b01, bl}],
                           x_ff[{2'b10, cl}], x_ff[{2'b11, dl}]);
         x_round[{2'b00, lane}] = q.a;
         x_round[{2'b01, bl}]   = q.b;
         x_round[{2'b10, cl}]   = q.c;
         x_round[{2'b11, dl}]   = q.d;
      end
   end

   always_comb begin
      state_in = state_ff;
      x_in     = x_ff;
      ctr_in   = ctr_ff;
      round_in = round_ff;
      blk_in   = blk_ff;
      done_in  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               x_in     = init_state(cfg, ctr);
               ctr_in   = ctr;
               round_in = '0;
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            x_in     = x_round;
            round_in = round_ff + 5'd1;
            if (round_ff == LAST_ROUND) begin
               state_in = ST_FINAL;
            end
         end
         ST_FINAL: begin
            for (int i = 0; i < 8; i++) begin
               blk_in[i] = {x_ff[2*i+1] + s_orig[2*i+1], x_ff[2*i] + s_orig[2*i]};
            end
            done_in  = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         done_ff  <= 1'b0;
         round_ff <= '0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         round_ff <= round_in;
      end
      x_ff   <= x_in;
      ctr_ff <= ctr_in;
      blk_ff <= blk_in;
   end

endmodule

FILE: rtl/core/cc20_back.sv
// Back end: pulls queued words, tracks counter and keystream position, XORs, drives results.
module cc20_back
   import cc20_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  cfg_type             cfg,
   input  logic                q_valid,
   input  item_type            q_item,
   output logic                q_pop,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [TDATA_W-1:0]  rsp_tdata
);

   typedef enum logic [1:0] {ST_IDLE, ST_GEN, ST_EMIT} back_state_type;

   back_state_type  state_ff, state_in;
   item_type        item_ff, item_in;
   logic [31:0]     counter_ff, counter_in;
   logic [2:0]      pos_ff, pos_in;
   logic            ks_valid_ff, ks_valid_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [TDATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic            core_start;
   logic [31:0]     gen_ctr;
   logic            core_done;
   block_type       ks_block;
   logic [63:0]     ks_word;
   logic [63:0]     xored;
   logic            out_free;

   cc20_core u_core (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .start  (core_start),
      .ctr    (gen_ctr),
      .done   (core_done),
      .block  (ks_block)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign ks_word    = ks_block[pos_ff];
   assign gen_ctr    = q_item.first ? cfg.start_counter : counter_ff;

   always_comb begin
      for (int j = 0; j < 8; j++) begin
         xored[8*j +: 8] = item_ff.byte_en[j] ? (item_ff.data[8*j +: 8] ^ ks_word[8*j +: 8])
                                              : 8'h00;
      end
   end

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      counter_in   = counter_ff;
      pos_in       = pos_ff;
      ks_valid_in  = ks_valid_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      q_pop        = 1'b0;
      core_start   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop   = 1'b1;
               item_in = q_item;
               if (q_item.first) begin
                  pos_in = '0;
               end
               if (q_item.first || !ks_valid_ff) begin
                  core_start  = 1'b1;
                  counter_in  = gen_ctr + 32'd1;
                  ks_valid_in = 1'b0;
                  state_in    = ST_GEN;
               end else begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_GEN: begin
            if (core_done) begin
               ks_valid_in = 1'b1;
               state_in    = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {4'h0, item_ff.count, xored};
               pos_in       = pos_ff + 3'd1;
               if (pos_ff == 3'd7) begin
                  ks_valid_in = 1'b0;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         counter_ff   <= '0;
         pos_ff       <= '0;
         ks_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         counter_ff   <= counter_in;
         pos_ff       <= pos_in;
         ks_valid_ff  <= ks_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff     <= item_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

FILE: rtl/core/chacha20_stream_cipher_top.sv
// ChaCha20 stream cipher top level: configuration registers, input queue and keystream engine.
//
// Usage: load key, nonce and start counter through the csr_ write port while the
// block is idle (index 0..3 key words, 4 nonce low, 5 nonce high, 6 start counter).
// Message words enter on the req_ stream: tdata carries 8 message bytes (byte 0 in
// bits 7:0) and the valid byte count; tuser marks the first word of a message,
// which reloads the block counter and restarts the keystream at byte zero.
// Each word leaves on the rsp_ stream XORed with the keystream, bytes past the
// count forced to zero. Encrypt and decrypt are the same transfer.
// A word that needs a fresh keystream block passes through the queue, the
// round loop of the iterative core, the feed-forward add and the output
// register; other words use the keystream block already held. The back end
// takes one word at a time and pulls the next queued word only once the
// result of the last has entered the output register; each new 64-byte block
// waits on the round loop in cc20_core.
// A four-deep input queue lets the front keep taking words while the back works
// or the receiver stalls; when rsp_tready is low the result holds in the output
// register and the queue fills, then req_tready drops.
// Reset (synchronous, active high) clears the configuration registers to zero,
// empties the queue and drops any held keystream block.
module chacha20_stream_cipher_top
   import cc20_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // configuration write port
   input  logic                csr_we,
   input  logic [CSR_AW-1:0]   csr_addr,
   input  logic [63:0]         csr_wdata,
   // message words in
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [TDATA_W-1:0]  req_tdata,   // [63:0] data_in, [67:64] byte_count, zero pad
   input  logic                req_tuser,   // [0] first_word
   // processed words out
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [TDATA_W-1:0]  rsp_tdata    // [63:0] data_out, [67:64] out_count, zero pad
);

   cfg_type   cfg_ff, cfg_in;
   logic      q_valid;
   logic      q_pop;
   item_type  q_item;

   // register file; writes outside the list are ignored
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_KEY_WORD0:     cfg_in.key_word0     = csr_wdata;
            CSR_KEY_WORD1:     cfg_in.key_word1     = csr_wdata;
            CSR_KEY_WORD2:     cfg_in.key_word2     = csr_wdata;
            CSR_KEY_WORD3:     cfg_in.key_word3     = csr_wdata;
            CSR_NONCE_LOW:     cfg_in.nonce_low     = csr_wdata;
            CSR_NONCE_HIGH:    cfg_in.nonce_high    = csr_wdata[31:0];
            CSR_START_COUNTER: cfg_in.start_counter = csr_wdata[31:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: accept, classify, queue
   cc20_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop)
   );

   // back: keystream generation, XOR and result register
   cc20_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

FILE: test/tb_top.sv
// Self-checking testbench for the ChaCha20 stream cipher top level.
`timescale 1ns / 1ps

module tb_top;
   import cc20_pkg::*;

   localparam int        HALF_PERIOD = 5;
   localparam int        RESET_CYCLES = 8;
   // The block is idle well within this many cycles after its last result.
   localparam int        SETTLE_CYCLES = 40;
   localparam int        LONG_HOLD = 300;
   localparam int        RANDOM_WORDS = 1000;
   localparam int        QUIET_AFTER = 880;
   localparam int        MAX_REPORTS = 200;
   localparam logic [3:0] WORD_BYTES = 4'd8;

   // ChaCha20 "expand 32-byte k" constants
   localparam logic [31:0] CONST0 = 32'h61707865;
   localparam logic [31:0] CONST1 = 32'h3320646e;
   localparam logic [31:0] CONST2 = 32'h79622d32;
   localparam logic [31:0] CONST3 = 32'h6b206574;

   typedef logic [15:0][31:0] chacha_state_type;
   typedef logic [7:0][63:0]  keystream_type;

   typedef struct packed {
      logic [63:0] data;
      logic [3:0]  count;
   } cipher_word_type;

   // ------------------------------------------------------------------
   // DUT hookup; every input has a known value from time zero
   // ------------------------------------------------------------------
   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_we = 1'b0;
   logic [CSR_AW-1:0]  csr_addr = '0;
   logic [63:0]        csr_wdata = '0;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [TDATA_W-1:0] req_tdata = '0;   // [63:0] data_in, [67:64] byte_count, zero pad
   logic               req_tuser = 1'b0; // [0] first_word
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [TDATA_W-1:0] rsp_tdata;        // [63:0] data_out, [67:64] out_count, zero pad

   chacha20_stream_cipher_top dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #HALF_PERIOD clock = ~clock;

   // ------------------------------------------------------------------
   // Shared testbench state
   // ------------------------------------------------------------------
   cipher_word_type expected_words[$];   // predicted results, oldest first
   int           mismatch_count = 0;
   bit           idle_on = 1'b1;      // random gaps on both sides
   int           hold_request = 0;    // long receiver hold-off, in cycles
   int           random_words = 0;

   // Predictor's copy of the configuration registers
   logic [63:0]  cfg_key [4];
   logic [63:0]  cfg_nonce_lo;
   logic [31:0]  cfg_nonce_hi;
   logic [31:0]  cfg_start;

   // Predictor's copy of the keystream state
   keystream_type ks_block;
   logic [31:0]  next_ctr;
   logic [2:0]   ks_pos;
   bit           ks_held;

   // ------------------------------------------------------------------
   // ChaCha20 keystream prediction
   // ------------------------------------------------------------------
   function automatic logic [31:0] rotl32(input logic [31:0] v, input int n);
      return (v << n) | (v >> (32 - n));
   endfunction

   function automatic chacha_state_type qmix(input chacha_state_type v,
                                             input int a, input int b,
                                             input int c, input int d);
      v[a] = v[a] + v[b]; v[d] = rotl32(v[d] ^ v[a], 16);
      v[c] = v[c] + v[d]; v[b] = rotl32(v[b] ^ v[c], 12);
      v[a] = v[a] + v[b]; v[d] = rotl32(v[d] ^ v[a], 8);
      v[c] = v[c] + v[d]; v[b] = rotl32(v[b] ^ v[c], 7);
      return v;
   endfunction

   // 64-byte block for one counter value, as eight little-endian 64-bit words
   function automatic keystream_type keystream_block(input logic [31:0] ctr);
      chacha_state_type s;
      chacha_state_type x;
      keystream_type    k;
      int               r;
      int               i;
      s[0]  = CONST0;
      s[1]  = CONST1;
      s[2]  = CONST2;
      s[3]  = CONST3;
      for (i = 0; i < 4; i++) begin
         s[4 + 2*i] = cfg_key[i][31:0];
         s[5 + 2*i] = cfg_key[i][63:32];
      end
      s[12] = ctr;
      s[13] = cfg_nonce_lo[31:0];
      s[14] = cfg_nonce_lo[63:32];
      s[15] = cfg_nonce_hi;
      x = s;
      for (r = 0; r < 10; r++) begin
         // column round
         x = qmix(x, 0, 4,  8, 12);
         x = qmix(x, 1, 5,  9, 13);
         x = qmix(x, 2, 6, 10, 14);
         x = qmix(x, 3, 7, 11, 15);
         // diagonal round
         x = qmix(x, 0, 5, 10, 15);
         x = qmix(x, 1, 6, 11, 12);
         x = qmix(x, 2, 7,  8, 13);
         x = qmix(x, 3, 4,  9, 14);
      end
      for (i = 0; i < 8; i++)
         k[i] = {x[2*i + 1] + s[2*i + 1], x[2*i] + s[2*i]};
      return k;
   endfunction

   // Advances the keystream state by one accepted word and returns its result
   function automatic cipher_word_type cipher_predict(input logic [63:0] data,
                                                      input logic [3:0]  count,
                                                      input bit          first);
      cipher_word_type r;
      logic [3:0]   n;
      logic [63:0]  mask;
      if (first) begin
         next_ctr = cfg_start;
         ks_pos   = '0;
         ks_held  = 1'b0;
      end
      if (!ks_held) begin
         ks_block = keystream_block(next_ctr);
         next_ctr = next_ctr + 32'd1;   // wraps mod 2^32
         ks_held  = 1'b1;
      end
      n = (count > WORD_BYTES) ? WORD_BYTES : count;
      if (n == 4'd0)
         mask = '0;
      else if (n == WORD_BYTES)
         mask = '1;
      else
         mask = (64'd1 << (8 * n)) - 64'd1;
      r.data  = (data ^ ks_block[ks_pos]) & mask;
      r.count = n;
      // a short or empty word still burns a whole keystream word
      ks_pos = ks_pos + 3'd1;
      if (ks_pos == 3'd0)
         ks_held = 1'b0;
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Reporting and result checking
   // ------------------------------------------------------------------
   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      if (mismatch_count < MAX_REPORTS)
         $display("%0t mismatch: %s got %h want %h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // Sampled at the falling edge: a result with valid and ready high here is
   // the transfer that happens at the next rising edge.
   always @(negedge clock) begin
      cipher_word_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         if (expected_words.size() == 0) begin
            report_mismatch("result with nothing expected", rsp_tdata[63:0], '0);
         end else begin
            want = expected_words.pop_front();
            if (rsp_tdata[63:0] !== want.data)
               report_mismatch("data_out", rsp_tdata[63:0], want.data);
            if (rsp_tdata[67:64] !== want.count)
               report_mismatch("out_count", {60'd0, rsp_tdata[67:64]}, {60'd0, want.count});
         end
      end
   end

   // ------------------------------------------------------------------
   // Receiver: random stall bursts, plus a long hold-off on request
   // ------------------------------------------------------------------
   initial begin
      int n;
      forever begin
         if (hold_request > 0) begin
            n = hold_request;
            hold_request = 0;
            rsp_tready <= 1'b0;
            repeat (n) @(posedge clock);
         end else if (idle_on && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // ------------------------------------------------------------------
   // Sender side; every task is entered and left at a rising edge
   // ------------------------------------------------------------------

   // One message word: optional gap, offer, wait for the transfer, predict.
   task automatic send_word(input logic [63:0] data, input logic [3:0] count,
                            input bit first);
      bit hit;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(TDATA_W - 68){1'b0}}, count, data};
      req_tuser  <= first;
      do begin
         @(negedge clock);
         hit = req_tready;
         @(posedge clock);
      end while (!hit);
      expected_words.push_back(cipher_predict(data, count, first));
   endtask

   // Sender pauses until every predicted result has been checked
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_words.size() != 0);
   endtask

   task automatic write_reg(input logic [CSR_AW-1:0] addr, input logic [63:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   // Registers change only once the block has gone quiet
   task automatic apply_config(input logic [63:0] k0, input logic [63:0] k1,
                               input logic [63:0] k2, input logic [63:0] k3,
                               input logic [63:0] nonce_lo,
                               input logic [31:0] nonce_hi,
                               input logic [31:0] start);
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      write_reg(CSR_KEY_WORD0, k0);
      write_reg(CSR_KEY_WORD1, k1);
      write_reg(CSR_KEY_WORD2, k2);
      write_reg(CSR_KEY_WORD3, k3);
      write_reg(CSR_NONCE_LOW, nonce_lo);
      write_reg(CSR_NONCE_HIGH, {32'd0, nonce_hi});
      write_reg(CSR_START_COUNTER, {32'd0, start});
      csr_we <= 1'b0;
      cfg_key[0]   = k0;
      cfg_key[1]   = k1;
      cfg_key[2]   = k2;
      cfg_key[3]   = k3;
      cfg_nonce_lo = nonce_lo;
      cfg_nonce_hi = nonce_hi;
      cfg_start    = start;
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Well-formed message: full words, a last word of one to eight bytes. A noisy
   // message mixes in odd byte counts and restarts in the middle.
   task automatic send_message(input int words, input bit noisy);
      int       i;
      logic [3:0] count;
      bit       first;
      for (i = 0; i < words; i++) begin
         if (noisy) begin
            count = 4'($urandom_range(0, 15));
            first = (i == 0) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 7) == 0);
         end else begin
            count = (i == words - 1) ? 4'($urandom_range(1, 8)) : WORD_BYTES;
            first = (i == 0);
         end
         send_word(rand64(), count, first);
         random_words++;
      end
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // No first word after reset: zero key, nonce and counter from reset
   task automatic test_no_first_word();
      send_word('1, WORD_BYTES, 1'b0);
      send_word('0, WORD_BYTES, 1'b0);
      send_word(rand64(), 4'd4, 1'b0);
   endtask

   // Key 00..1f, nonce 00:00:00:09:00:00:00:4a:00:00:00:00, counter 1,
   // with the byte-count corner cases and a restart in mid-block
   task automatic test_known_key();
      apply_config(64'h0706050403020100, 64'h0f0e0d0c0b0a0908,
                   64'h1716151413121110, 64'h1f1e1d1c1b1a1918,
                   64'h4a00000009000000, 32'h00000000, 32'h00000001);
      send_word('0, WORD_BYTES, 1'b1);
      send_word('1, WORD_BYTES, 1'b0);
      send_word(rand64(), 4'd0, 1'b0);    // empty word still uses a keystream word
      send_word('1, 4'd1, 1'b0);
      send_word(rand64(), 4'd7, 1'b0);    // short word in mid-message
      send_word('1, 4'd9, 1'b0);          // counts above eight clamp
      send_word('1, 4'd15, 1'b0);
      send_word(rand64(), WORD_BYTES, 1'b0);
      send_word(rand64(), WORD_BYTES, 1'b0); // crosses into the next block
      send_word(rand64(), 4'd3, 1'b1);    // restart in mid-block
      send_word(rand64(), WORD_BYTES, 1'b0);
      send_word(rand64(), 4'd6, 1'b0);
   endtask

   // All-ones registers, counter one below wrap: the second block uses zero
   task automatic test_counter_wrap();
      int i;
      apply_config('1, '1, '1, '1, '1, '1, 32'hffffffff);
      for (i = 0; i < 10; i++)
         send_word(rand64(), WORD_BYTES, i == 0);
   endtask

   // Receiver stalls long enough for the queue to fill and req_tready to drop
   task automatic test_backpressure();
      apply_config(rand64(), rand64(), rand64(), rand64(), rand64(), $urandom, $urandom);
      hold_request = LONG_HOLD;
      send_message(40, 1'b0);
      drain_results();
   endtask

   // Random phases, each with its own register setting
   task automatic test_random_traffic();
      int         phase;
      int         phase_words;
      int         words;
      logic [31:0] start;
      phase = 0;
      while (random_words < RANDOM_WORDS) begin
         case (phase)
            0: apply_config('0, '0, '0, '0, '0, '0, '0);
            1: apply_config('1, '1, '1, '1, '1, '1, '1);
            default: begin
               start = ($urandom_range(0, 3) == 0) ? 32'hffffffff - $urandom_range(0, 3)
                                                   : $urandom;
               apply_config(rand64(), rand64(), rand64(), rand64(), rand64(),
                            $urandom, start);
            end
         endcase
         phase_words = 0;
         while (phase_words < 120 && random_words < RANDOM_WORDS) begin
            if (random_words >= QUIET_AFTER)
               idle_on = 1'b0;   // last stretch runs at full rate
            words = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
                                                : $urandom_range(1, 12);
            send_message(words, $urandom_range(0, 4) == 0);
            phase_words += words;
         end
         phase++;
      end
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------
   initial begin
      cfg_key[0] = '0; cfg_key[1] = '0; cfg_key[2] = '0; cfg_key[3] = '0;
      cfg_nonce_lo = '0;
      cfg_nonce_hi = '0;
      cfg_start    = '0;
      ks_block = '0;
      next_ctr = '0;
      ks_pos   = '0;
      ks_held  = 1'b0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_no_first_word();
      test_known_key();
      test_counter_wrap();
      test_backpressure();
      test_random_traffic();

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Run limit: several times the slowest expected run
   initial begin
      #(4_000_000);
      $display("status: fail");
      $finish;
   end

endmodule

FILE: chacha20_stream_cipher_top.f
rtl/core/cc20_pkg.sv
rtl/core/cc20_front.sv
rtl/core/cc20_core.sv
rtl/core/cc20_back.sv
rtl/core/chacha20_stream_cipher_top.sv
test/tb_top.sv
